/* sv/mare_pkg.sv */
// mare_pkg: shared types, opcode codes and widths of the register-file execute core
// no dependencies; imported by mare_decode, mare_exec, the top level and the testbench
`default_nettype none
package mare_pkg;

	localparam int REG_AW    = 5;
	localparam int BANK_DEPTH = 16;
	localparam int BANK_AW   = 4;
	localparam int OP_W      = 5;

	localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
	localparam logic [OP_W-1:0] OP_ADC   = 5'd1;
	localparam logic [OP_W-1:0] OP_AND   = 5'd2;
	localparam logic [OP_W-1:0] OP_EOR   = 5'd3;
	localparam logic [OP_W-1:0] OP_OR    = 5'd4;
	localparam logic [OP_W-1:0] OP_SUB   = 5'd5;
	localparam logic [OP_W-1:0] OP_SBC   = 5'd6;
	localparam logic [OP_W-1:0] OP_ANDI  = 5'd7;
	localparam logic [OP_W-1:0] OP_ORI   = 5'd8;
	localparam logic [OP_W-1:0] OP_SUBI  = 5'd9;
	localparam logic [OP_W-1:0] OP_SBCI  = 5'd10;
	localparam logic [OP_W-1:0] OP_ADIW  = 5'd11;
	localparam logic [OP_W-1:0] OP_SBIW  = 5'd12;
	localparam logic [OP_W-1:0] OP_BSET  = 5'd13;
	localparam logic [OP_W-1:0] OP_BCLR  = 5'd14;
	localparam logic [OP_W-1:0] OP_COM   = 5'd15;
	localparam logic [OP_W-1:0] OP_NEG   = 5'd16;
	localparam logic [OP_W-1:0] OP_SWAP  = 5'd17;
	localparam logic [OP_W-1:0] OP_INC   = 5'd18;
	localparam logic [OP_W-1:0] OP_ASR   = 5'd19;
	localparam logic [OP_W-1:0] OP_LSR   = 5'd20;
	localparam logic [OP_W-1:0] OP_ROR   = 5'd21;
	localparam logic [OP_W-1:0] OP_DEC   = 5'd22;
	localparam logic [OP_W-1:0] OP_SER   = 5'd23;
	localparam logic [OP_W-1:0] OP_MUL   = 5'd24;
	localparam logic [OP_W-1:0] OP_MULS  = 5'd25;
	localparam logic [OP_W-1:0] OP_MULSU = 5'd26;
	localparam logic [OP_W-1:0] OP_BST   = 5'd27;
	localparam logic [OP_W-1:0] OP_BLD   = 5'd28;
	localparam logic [OP_W-1:0] OP_UNK   = 5'd29;

	localparam int SREG_C = 0;
	localparam int SREG_T = 6;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [REG_AW-1:0] ra;
		logic [REG_AW-1:0] rb;
		logic [7:0]        imm;
	} dec_t;

	typedef struct packed {
		logic [REG_AW-1:0] dest;
		logic              lo_wr;
		logic [7:0]        lo_val;
		logic              hi_wr;
		logic [7:0]        hi_val;
		logic [7:0]        status;
		logic              unk;
	} res_t;

	typedef struct packed {
		logic              lo_en;
		logic [REG_AW-1:0] lo_addr;
		logic [7:0]        lo_data;
		logic              hi_en;
		logic [REG_AW-1:0] hi_addr;
		logic [7:0]        hi_data;
	} wr_t;

endpackage
`default_nettype wire

/* sv/mare_ram.sv */
// mare_ram: generic ram, one write port, two registered read ports
// no dependencies
`default_nettype none
module mare_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
`default_nettype wire

/* sv/mare_decode.sv */
// mare_decode: instruction word decode into opcode, operand registers and immediate
// depends on mare_pkg
`default_nettype none
module mare_decode
	import mare_pkg::*;
(
	input  wire logic [15:0] word,
	output dec_t             dec
);

	logic [REG_AW-1:0] d5;
	logic [REG_AW-1:0] r5;
	logic [REG_AW-1:0] dhi;
	logic [7:0]        k8;

	always_comb begin
		d5  = word[8:4];
		r5  = {word[9], word[3:0]};
		dhi = {1'b1, word[7:4]};
		k8  = {word[11:8], word[3:0]};
		dec.op  = OP_UNK;
		dec.ra  = d5;
		dec.rb  = r5;
		dec.imm = 8'd0;
		if ((word & 16'hFC00) == 16'h0C00) begin
			dec.op = OP_ADD;
		end else if ((word & 16'hFC00) == 16'h1C00) begin
			dec.op = OP_ADC;
		end else if ((word & 16'hFC00) == 16'h2000) begin
			dec.op = OP_AND;
		end else if ((word & 16'hFC00) == 16'h2400) begin
			dec.op = OP_EOR;
		end else if ((word & 16'hFC00) == 16'h2800) begin
			dec.op = OP_OR;
		end else if ((word & 16'hFC00) == 16'h1800) begin
			dec.op = OP_SUB;
		end else if ((word & 16'hFC00) == 16'h0800) begin
			dec.op = OP_SBC;
		end else if (word[15:12] == 4'h7) begin
			dec.op = OP_ANDI; dec.ra = dhi; dec.imm = k8;
		end else if (word[15:12] == 4'h6) begin
			dec.op = OP_ORI; dec.ra = dhi; dec.imm = k8;
		end else if (word[15:12] == 4'h5) begin
			dec.op = OP_SUBI; dec.ra = dhi; dec.imm = k8;
		end else if (word[15:12] == 4'h4) begin
			dec.op = OP_SBCI; dec.ra = dhi; dec.imm = k8;
		end else if ((word & 16'hFE00) == 16'h9600) begin
			dec.op  = word[8] ? OP_SBIW : OP_ADIW;
			dec.ra  = {2'b11, word[5:4], 1'b0};
			dec.rb  = {2'b11, word[5:4], 1'b1};
			dec.imm = {2'b00, word[7:6], word[3:0]};
		end else if ((word & 16'hFF8F) == 16'h9408) begin
			dec.op = OP_BSET; dec.imm = {5'd0, word[6:4]};
		end else if ((word & 16'hFF8F) == 16'h9488) begin
			dec.op = OP_BCLR; dec.imm = {5'd0, word[6:4]};
		end else if ((word & 16'hFE00) == 16'h9400) begin
			case (word[3:0])
				4'h0: dec.op = OP_COM;
				4'h1: dec.op = OP_NEG;
				4'h2: dec.op = OP_SWAP;
				4'h3: dec.op = OP_INC;
				4'h5: dec.op = OP_ASR;
				4'h6: dec.op = OP_LSR;
				4'h7: dec.op = OP_ROR;
				4'hA: dec.op = OP_DEC;
				default: dec.op = OP_UNK;
			endcase
		end else if ((word & 16'hFF0F) == 16'hEF0F) begin
			dec.op = OP_SER; dec.ra = dhi;
		end else if ((word & 16'hFC00) == 16'h9C00) begin
			dec.op = OP_MUL;
		end else if (word[15:8] == 8'h02) begin
			dec.op = OP_MULS; dec.ra = dhi; dec.rb = {1'b1, word[3:0]};
		end else if ((word & 16'hFF88) == 16'h0300) begin
			dec.op = OP_MULSU;
			dec.ra = {2'b10, word[6:4]};
			dec.rb = {2'b10, word[2:0]};
		end else if ((word & 16'hFE08) == 16'hFA00) begin
			dec.op = OP_BST; dec.imm = {5'd0, word[2:0]};
		end else if ((word & 16'hFE08) == 16'hF800) begin
			dec.op = OP_BLD; dec.imm = {5'd0, word[2:0]};
		end
	end

endmodule
`default_nettype wire

/* sv/mare_exec.sv */
// mare_exec: alu, word add, multiplier and status bit operations of one instruction
// depends on mare_pkg
`default_nettype none
module mare_exec
	import mare_pkg::*;
(
	input  wire dec_t        dec,
	input  wire logic [7:0]  a,
	input  wire logic [7:0]  b,
	input  wire logic [7:0]  status,
	output res_t             res
);

	logic               c;
	logic               t;
	logic [15:0]        word_in;
	logic [15:0]        word_out;
	logic signed [8:0]  ma;
	logic signed [8:0]  mb;
	logic signed [17:0] prod;
	logic [7:0]         bit_mask;

	always_comb begin
		c        = status[SREG_C];
		t        = status[SREG_T];
		word_in  = {b, a};
		word_out = (dec.op == OP_SBIW) ? word_in - {10'd0, dec.imm[5:0]}
		                               : word_in + {10'd0, dec.imm[5:0]};
		ma       = {(dec.op == OP_MULS || dec.op == OP_MULSU) & a[7], a};
		mb       = {(dec.op == OP_MULS) & b[7], b};
		prod     = ma * mb;
		bit_mask = 8'd1 << dec.imm[2:0];

		res.dest   = dec.ra;
		res.lo_wr  = 1'b0;
		res.lo_val = 8'd0;
		res.hi_wr  = 1'b0;
		res.hi_val = 8'd0;
		res.status = status;
		res.unk    = 1'b0;
		case (dec.op)
			OP_ADD:  begin res.lo_wr = 1'b1; res.lo_val = a + b; end
			OP_ADC:  begin res.lo_wr = 1'b1; res.lo_val = a + b + {7'd0, c}; end
			OP_AND:  begin res.lo_wr = 1'b1; res.lo_val = a & b; end
			OP_EOR:  begin res.lo_wr = 1'b1; res.lo_val = a ^ b; end
			OP_OR:   begin res.lo_wr = 1'b1; res.lo_val = a | b; end
			OP_SUB:  begin res.lo_wr = 1'b1; res.lo_val = a - b; end
			OP_SBC:  begin res.lo_wr = 1'b1; res.lo_val = a - b - {7'd0, c}; end
			OP_ANDI: begin res.lo_wr = 1'b1; res.lo_val = a & dec.imm; end
			OP_ORI:  begin res.lo_wr = 1'b1; res.lo_val = a | dec.imm; end
			OP_SUBI: begin res.lo_wr = 1'b1; res.lo_val = a - dec.imm; end
			OP_SBCI: begin res.lo_wr = 1'b1; res.lo_val = a - dec.imm - {7'd0, c}; end
			OP_ADIW, OP_SBIW: begin
				res.lo_wr  = 1'b1;
				res.hi_wr  = 1'b1;
				res.lo_val = word_out[7:0];
				res.hi_val = word_out[15:8];
			end
			OP_BSET: res.status = status | bit_mask;
			OP_BCLR: res.status = status & ~bit_mask;
			OP_COM:  begin res.lo_wr = 1'b1; res.lo_val = ~a; end
			OP_NEG:  begin res.lo_wr = 1'b1; res.lo_val = 8'd0 - a; end
			OP_SWAP: begin res.lo_wr = 1'b1; res.lo_val = {a[3:0], a[7:4]}; end
			OP_INC:  begin res.lo_wr = 1'b1; res.lo_val = a + 8'd1; end
			OP_DEC:  begin res.lo_wr = 1'b1; res.lo_val = a - 8'd1; end
			OP_ASR: begin
				res.lo_wr = 1'b1; res.lo_val = {a[7], a[7:1]}; res.status[SREG_C] = a[0];
			end
			OP_LSR: begin
				res.lo_wr = 1'b1; res.lo_val = {1'b0, a[7:1]}; res.status[SREG_C] = a[0];
			end
			OP_ROR: begin
				res.lo_wr = 1'b1; res.lo_val = {c, a[7:1]}; res.status[SREG_C] = a[0];
			end
			OP_SER:  begin res.lo_wr = 1'b1; res.lo_val = 8'hFF; end
			OP_MUL, OP_MULS, OP_MULSU: begin
				res.dest   = '0;
				res.lo_wr  = 1'b1;
				res.hi_wr  = 1'b1;
				res.lo_val = prod[7:0];
				res.hi_val = prod[15:8];
			end
			OP_BST:  res.status[SREG_T] = a[dec.imm[2:0]];
			OP_BLD: begin
				res.lo_wr  = 1'b1;
				res.lo_val = (a & ~bit_mask) | (t ? bit_mask : 8'd0);
			end
			default: res.unk = 1'b1;
		endcase
		if (!res.lo_wr) begin
			res.dest   = '0;
			res.lo_val = 8'd0;
		end
	end

endmodule
`default_nettype wire

/* sv/mcu_alu_register_file_execute_core.sv */
// mcu_alu_register_file_execute_core: top level, banked register file, pipeline and handshakes
// depends on mare_pkg, mare_ram, mare_decode, mare_exec
//
// Executes one 16-bit instruction word per clock against a 32 x 8 register file and an
// 8-bit status register. An accepted beat reads its two operand registers from two
// synchronous RAM banks (even and odd registers, two read ports each) at the accept edge;
// the decoded beat then executes from the stage register and writes back as its result
// moves into the output register, where it waits until taken. A new instruction is taken
// every cycle while the output side keeps up; the previous instruction's write-back is
// forwarded to the operands. Register file contents read as zero after reset (per-register
// valid flags), with no clearing pass.
`default_nettype none
module mcu_alu_register_file_execute_core
	import mare_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // instr_word
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// low_dest, low_written, low_value, high_written, high_value, status_now, zero pad
	output logic      [31:0] m_axis_tdata,
	output logic             m_axis_tuser   // unknown_op
);

	dec_t                dec_in;
	dec_t                dec_s1;
	logic                valid_s1;
	logic                in_accept;
	logic                s1_fire;
	logic [7:0]          even_a, even_b, odd_a, odd_b;
	logic [7:0]          opnd_a, opnd_b;
	logic [31:0]         rf_valid_q;
	logic [7:0]          status_q;
	wr_t                 wr;
	wr_t                 fwd_q;
	res_t                res;
	res_t                out_q;
	logic                out_valid_q;
	logic                even_we, odd_we;
	logic [BANK_AW-1:0]  even_waddr, odd_waddr;
	logic [7:0]          even_wdata, odd_wdata;

	function automatic logic [7:0] operand(input logic [REG_AW-1:0] idx,
		input logic [7:0] ev, input logic [7:0] od, input logic [31:0] vld, input wr_t f);
		logic [7:0] v;
		v = idx[0] ? od : ev;
		if (!vld[idx]) begin
			v = 8'd0;
		end
		if (f.lo_en && f.lo_addr == idx) begin
			v = f.lo_data;
		end else if (f.hi_en && f.hi_addr == idx) begin
			v = f.hi_data;
		end
		return v;
	endfunction

	mare_decode u_decode (
		.word(s_axis_tdata),
		.dec (dec_in)
	);

	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign s1_fire       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_fire;

	mare_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_even (
		.clk    (clk),
		.we     (even_we),
		.waddr  (even_waddr),
		.wdata  (even_wdata),
		.re     (in_accept),
		.raddr_a(dec_in.ra[REG_AW-1:1]),
		.raddr_b(dec_in.rb[REG_AW-1:1]),
		.rdata_a(even_a),
		.rdata_b(even_b)
	);

	mare_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_odd (
		.clk    (clk),
		.we     (odd_we),
		.waddr  (odd_waddr),
		.wdata  (odd_wdata),
		.re     (in_accept),
		.raddr_a(dec_in.ra[REG_AW-1:1]),
		.raddr_b(dec_in.rb[REG_AW-1:1]),
		.rdata_a(odd_a),
		.rdata_b(odd_b)
	);

	assign opnd_a = operand(dec_s1.ra, even_a, odd_a, rf_valid_q, fwd_q);
	assign opnd_b = operand(dec_s1.rb, even_b, odd_b, rf_valid_q, fwd_q);

	mare_exec u_exec (
		.dec   (dec_s1),
		.a     (opnd_a),
		.b     (opnd_b),
		.status(status_q),
		.res   (res)
	);

	// write-back of the executing beat, split over the two banks
	always_comb begin
		wr.lo_en   = s1_fire && res.lo_wr;
		wr.lo_addr = res.dest;
		wr.lo_data = res.lo_val;
		wr.hi_en   = s1_fire && res.hi_wr;
		wr.hi_addr = res.dest + 5'd1;
		wr.hi_data = res.hi_val;

		even_we    = (wr.lo_en && !wr.lo_addr[0]) || (wr.hi_en && !wr.hi_addr[0]);
		even_waddr = (wr.lo_en && !wr.lo_addr[0]) ? wr.lo_addr[REG_AW-1:1]
		                                          : wr.hi_addr[REG_AW-1:1];
		even_wdata = (wr.lo_en && !wr.lo_addr[0]) ? wr.lo_data : wr.hi_data;
		odd_we     = (wr.lo_en && wr.lo_addr[0]) || (wr.hi_en && wr.hi_addr[0]);
		odd_waddr  = (wr.lo_en && wr.lo_addr[0]) ? wr.lo_addr[REG_AW-1:1]
		                                         : wr.hi_addr[REG_AW-1:1];
		odd_wdata  = (wr.lo_en && wr.lo_addr[0]) ? wr.lo_data : wr.hi_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= 8'd0;
			rf_valid_q  <= '0;
			fwd_q       <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
				fwd_q    <= wr;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
				status_q    <= res.status;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (wr.lo_en) begin
				rf_valid_q[wr.lo_addr] <= 1'b1;
			end
			if (wr.hi_en) begin
				rf_valid_q[wr.hi_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			dec_s1 <= dec_in;
		end
		if (s1_fire) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.status, out_q.hi_val, out_q.hi_wr,
	                        out_q.lo_val, out_q.lo_wr, out_q.dest};
	assign m_axis_tuser  = out_q.unk;

endmodule
`default_nettype wire

/* sv/mare_chk.sv */
// mare_chk: port-level checks of the execute core's result beats, bound to the top level
// depends on mcu_alu_register_file_execute_core
`default_nettype none
module mare_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	// unknown beat writes nothing
	a_unknown_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[22:0] == 23'd0)
		else $error("unknown opcode beat reports a register write");

	// no low write means zero dest and value
	a_lo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[13:0] == 14'd0)
		else $error("unwritten low register has nonzero fields");

	// word writes always start at an even register
	a_pair_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[5] && !m_axis_tdata[0])
		else $error("high write without an even low write");

	a_hi_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[14] |-> m_axis_tdata[22:15] == 8'd0)
		else $error("unwritten high register has nonzero value");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result beat changed");

endmodule

bind mcu_alu_register_file_execute_core mare_chk u_mare_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
`default_nettype wire

/* verif/mcu_alu_register_file_execute_core_tb.sv */
// mcu_alu_register_file_execute_core_tb: self-checking testbench for the execute core
// drives instruction beats with random gaps and back-pressure, predicts every result beat
// depends on mare_pkg and mcu_alu_register_file_execute_core
`default_nettype none
module mcu_alu_register_file_execute_core_tb
	import mare_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;

	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit hold_request = 1'b0;

	always #6 clk = ~clk;

	mcu_alu_register_file_execute_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	class exec_checker;
		logic [7:0] gpr [32];
		logic [7:0] sreg;
		res_t       expected_results [$];
		int         errors;
		int         beat_no;

		function new();
			foreach (gpr[i]) gpr[i] = 8'h00;
			sreg = 8'h00;
			errors = 0;
			beat_no = 0;
		endfunction

		function logic [OP_W-1:0] decode(logic [15:0] w);
			logic [OP_W-1:0] op;
			casez (w)
				16'b0000_11??_????_????: op = OP_ADD;
				16'b0001_11??_????_????: op = OP_ADC;
				16'b0010_00??_????_????: op = OP_AND;
				16'b0010_01??_????_????: op = OP_EOR;
				16'b0010_10??_????_????: op = OP_OR;
				16'b0001_10??_????_????: op = OP_SUB;
				16'b0000_10??_????_????: op = OP_SBC;
				16'b0111_????_????_????: op = OP_ANDI;
				16'b0110_????_????_????: op = OP_ORI;
				16'b0101_????_????_????: op = OP_SUBI;
				16'b0100_????_????_????: op = OP_SBCI;
				16'b1001_0110_????_????: op = OP_ADIW;
				16'b1001_0111_????_????: op = OP_SBIW;
				16'b1001_0100_0???_1000: op = OP_BSET;
				16'b1001_0100_1???_1000: op = OP_BCLR;
				16'b1001_010?_????_????: begin
					case (w[3:0])
						4'h0: op = OP_COM;
						4'h1: op = OP_NEG;
						4'h2: op = OP_SWAP;
						4'h3: op = OP_INC;
						4'h5: op = OP_ASR;
						4'h6: op = OP_LSR;
						4'h7: op = OP_ROR;
						4'hA: op = OP_DEC;
						default: op = OP_UNK;
					endcase
				end
				16'b1110_1111_????_1111: op = OP_SER;
				16'b1001_11??_????_????: op = OP_MUL;
				16'b0000_0010_????_????: op = OP_MULS;
				16'b0000_0011_0???_0???: op = OP_MULSU;
				16'b1111_101?_????_0???: op = OP_BST;
				16'b1111_100?_????_0???: op = OP_BLD;
				default: op = OP_UNK;
			endcase
			return op;
		endfunction

		// executes one word on the local register copy and returns the result beat
		function res_t execute(logic [15:0] w);
			res_t            r;
			logic [OP_W-1:0] op;
			logic [4:0]      rd, rs, rh;
			logic [7:0]      k8, v, a, b;
			logic [5:0]      k6;
			logic [15:0]     word, prod;
			logic            c;
			r = '0;
			op = decode(w);
			rd = w[8:4];
			rs = {w[9], w[3:0]};
			rh = {1'b1, w[7:4]};
			k8 = {w[11:8], w[3:0]};
			c = sreg[SREG_C];
			v = gpr[rd];
			r.dest = rd;
			r.lo_wr = 1'b1;
			case (op)
				OP_ADD: r.lo_val = gpr[rd] + gpr[rs];
				OP_ADC: r.lo_val = gpr[rd] + gpr[rs] + {7'd0, c};
				OP_AND: r.lo_val = gpr[rd] & gpr[rs];
				OP_EOR: r.lo_val = gpr[rd] ^ gpr[rs];
				OP_OR: r.lo_val = gpr[rd] | gpr[rs];
				OP_SUB: r.lo_val = gpr[rd] - gpr[rs];
				OP_SBC: r.lo_val = gpr[rd] - gpr[rs] - {7'd0, c};
				OP_ANDI: begin
					r.dest = rh;
					r.lo_val = gpr[rh] & k8;
				end
				OP_ORI: begin
					r.dest = rh;
					r.lo_val = gpr[rh] | k8;
				end
				OP_SUBI: begin
					r.dest = rh;
					r.lo_val = gpr[rh] - k8;
				end
				OP_SBCI: begin
					r.dest = rh;
					r.lo_val = gpr[rh] - k8 - {7'd0, c};
				end
				OP_ADIW, OP_SBIW: begin
					r.dest = 5'd24 + {2'b00, w[5:4], 1'b0};
					k6 = {w[7:6], w[3:0]};
					word = {gpr[r.dest + 5'd1], gpr[r.dest]};
					word = (op == OP_SBIW) ? word - {10'd0, k6} : word + {10'd0, k6};
					r.lo_val = word[7:0];
					r.hi_wr = 1'b1;
					r.hi_val = word[15:8];
				end
				OP_BSET, OP_BCLR: begin
					sreg[w[6:4]] = (op == OP_BSET);
					r.dest = '0;
					r.lo_wr = 1'b0;
				end
				OP_COM: r.lo_val = ~v;
				OP_NEG: r.lo_val = 8'h00 - v;
				OP_SWAP: r.lo_val = {v[3:0], v[7:4]};
				OP_INC: r.lo_val = v + 8'h01;
				OP_DEC: r.lo_val = v - 8'h01;
				OP_ASR, OP_LSR, OP_ROR: begin
					if (op == OP_ASR)
						r.lo_val = {v[7], v[7:1]};
					else if (op == OP_LSR)
						r.lo_val = {1'b0, v[7:1]};
					else
						r.lo_val = {c, v[7:1]};
					sreg[SREG_C] = v[0];
				end
				OP_SER: begin
					r.dest = rh;
					r.lo_val = 8'hFF;
				end
				OP_MUL, OP_MULS, OP_MULSU: begin
					if (op == OP_MUL) begin
						a = gpr[rd];
						b = gpr[rs];
						prod = {8'h00, a} * {8'h00, b};
					end else if (op == OP_MULS) begin
						a = gpr[rh];
						b = gpr[{1'b1, w[3:0]}];
						prod = {{8{a[7]}}, a} * {{8{b[7]}}, b};
					end else begin
						a = gpr[{2'b10, w[6:4]}];
						b = gpr[{2'b10, w[2:0]}];
						prod = {{8{a[7]}}, a} * {8'h00, b};
					end
					r.dest = '0;
					r.lo_val = prod[7:0];
					r.hi_wr = 1'b1;
					r.hi_val = prod[15:8];
				end
				OP_BST: begin
					sreg[SREG_T] = v[w[2:0]];
					r.dest = '0;
					r.lo_wr = 1'b0;
				end
				OP_BLD: begin
					v[w[2:0]] = sreg[SREG_T];
					r.lo_val = v;
				end
				default: begin
					r.dest = '0;
					r.lo_wr = 1'b0;
					r.unk = 1'b1;
				end
			endcase
			if (r.lo_wr)
				gpr[r.dest] = r.lo_val;
			if (r.hi_wr)
				gpr[r.dest + 5'd1] = r.hi_val;
			r.status = sreg;
			return r;
		endfunction

		function void note_instr(logic [15:0] w);
			expected_results.push_back(execute(w));
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("result beat %0d: %s is 0x%0h, expected 0x%0h", beat_no, what, got, want);
			errors++;
		endtask

		task check_result(logic [31:0] data, logic unk);
			res_t want;
			beat_no++;
			if (expected_results.size() == 0) begin
				report("unexpected beat, tdata", data, 0);
				return;
			end
			want = expected_results.pop_front();
			if (data[4:0] !== want.dest)
				report("low_dest", 32'(data[4:0]), 32'(want.dest));
			if (data[5] !== want.lo_wr)
				report("low_written", 32'(data[5]), 32'(want.lo_wr));
			if (data[13:6] !== want.lo_val)
				report("low_value", 32'(data[13:6]), 32'(want.lo_val));
			if (data[14] !== want.hi_wr)
				report("high_written", 32'(data[14]), 32'(want.hi_wr));
			if (data[22:15] !== want.hi_val)
				report("high_value", 32'(data[22:15]), 32'(want.hi_val));
			if (data[30:23] !== want.status)
				report("status_now", 32'(data[30:23]), 32'(want.status));
			if (unk !== want.unk)
				report("unknown_op", 32'(unk), 32'(want.unk));
		endtask
	endclass

	exec_checker chk = new();

	// fixed opcode bits of each instruction, the rest taken from the operand word
	function automatic logic [15:0] encode(logic [OP_W-1:0] op, logic [15:0] opnd);
		logic [15:0] fix, val;
		case (op)
			OP_ADD: {fix, val} = {16'hFC00, 16'h0C00};
			OP_ADC: {fix, val} = {16'hFC00, 16'h1C00};
			OP_AND: {fix, val} = {16'hFC00, 16'h2000};
			OP_EOR: {fix, val} = {16'hFC00, 16'h2400};
			OP_OR: {fix, val} = {16'hFC00, 16'h2800};
			OP_SUB: {fix, val} = {16'hFC00, 16'h1800};
			OP_SBC: {fix, val} = {16'hFC00, 16'h0800};
			OP_ANDI: {fix, val} = {16'hF000, 16'h7000};
			OP_ORI: {fix, val} = {16'hF000, 16'h6000};
			OP_SUBI: {fix, val} = {16'hF000, 16'h5000};
			OP_SBCI: {fix, val} = {16'hF000, 16'h4000};
			OP_ADIW: {fix, val} = {16'hFF00, 16'h9600};
			OP_SBIW: {fix, val} = {16'hFF00, 16'h9700};
			OP_BSET: {fix, val} = {16'hFF8F, 16'h9408};
			OP_BCLR: {fix, val} = {16'hFF8F, 16'h9488};
			OP_COM: {fix, val} = {16'hFE0F, 16'h9400};
			OP_NEG: {fix, val} = {16'hFE0F, 16'h9401};
			OP_SWAP: {fix, val} = {16'hFE0F, 16'h9402};
			OP_INC: {fix, val} = {16'hFE0F, 16'h9403};
			OP_ASR: {fix, val} = {16'hFE0F, 16'h9405};
			OP_LSR: {fix, val} = {16'hFE0F, 16'h9406};
			OP_ROR: {fix, val} = {16'hFE0F, 16'h9407};
			OP_DEC: {fix, val} = {16'hFE0F, 16'h940A};
			OP_SER: {fix, val} = {16'hFF0F, 16'hEF0F};
			OP_MUL: {fix, val} = {16'hFC00, 16'h9C00};
			OP_MULS: {fix, val} = {16'hFF00, 16'h0200};
			OP_MULSU: {fix, val} = {16'hFF88, 16'h0300};
			OP_BST: {fix, val} = {16'hFE08, 16'hFA00};
			OP_BLD: {fix, val} = {16'hFE08, 16'hF800};
			default: {fix, val} = {16'h0000, 16'h0000};
		endcase
		return (opnd & ~fix) | val;
	endfunction

	function automatic int pick_gap(bit steady);
		int roll;
		roll = $urandom_range(99, 0);
		if (steady || roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		if (roll < 98)
			return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				chk.check_result(m_axis_tdata, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				chk.note_instr(s_axis_tdata);
		end
	end

	task automatic send_instr(input logic [15:0] w);
		int n;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		do @(posedge clk); while (!s_axis_tready);
		n = pick_gap(tx_steady);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_random(input int count);
		logic [15:0] opnd;
		logic [OP_W-1:0] op;
		repeat (count) begin
			opnd = 16'($urandom);
			// half of the beats work on a few registers so that values build up
			if ($urandom_range(1, 0))
				opnd = (opnd & 16'hFC33) | 16'h0300;
			op = OP_W'($urandom_range(int'(OP_BLD), int'(OP_ADD)));
			if ($urandom_range(99, 0) < 15)
				send_instr(16'($urandom));
			else
				send_instr(encode(op, opnd));
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (chk.expected_results.size() != 0);
	endtask

	initial begin : receiver
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(12, 1)) @(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = pick_gap(rx_steady);
			end
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [15:0] odd_words [4];
		odd_words = '{16'h0000, 16'hEF0E, 16'h0388, 16'h9404};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every instruction with all operand bits set, then undecoded words
		for (int i = int'(OP_ADD); i <= int'(OP_BLD); i++)
			send_instr(encode(OP_W'(i), 16'hFFFF));
		foreach (odd_words[i])
			send_instr(odd_words[i]);

		send_random(300);

		// receiver stalls for a long stretch while beats keep coming
		hold_request = 1'b1;
		tx_steady = 1'b1;
		send_random(150);
		wait_drained();

		rx_steady = 1'b1;
		send_random(150);

		tx_steady = 1'b0;
		rx_steady = 1'b0;
		send_random(250);

		wait_drained();
		repeat (10) @(posedge clk);
		if (chk.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#6_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
